/* rtl/two_frame_shard_reassembler_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the two-frame shard reassembler
// Implication checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TWO_FRAME_SHARD_REASSEMBLER_CORE_MACROS_SVH
`define TWO_FRAME_SHARD_REASSEMBLER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TFSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TFSR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TFSR_ASSERT_IMP(lbl, ante, cons, msg)
`define TFSR_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/tfsr_pkg.sv */
// ----------------------------------------------------------------------------
// tfsr_pkg
// Shared constants and event codes of the two-frame shard reassembler.
// ----------------------------------------------------------------------------
package tfsr_pkg;

  localparam int DEF_MAX_SHARDS = 32;
  localparam int DEF_FRAME_BITS = 32;

  typedef enum logic [1:0] {
    EV_RELEASE = 2'd0,
    EV_DONE    = 2'd1,
    EV_ABANDON = 2'd2
  } event_kind_t;

endpackage

/* rtl/tfsr_ram.sv */
// ----------------------------------------------------------------------------
// tfsr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tfsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/two_frame_shard_reassembler_core.sv */
// ----------------------------------------------------------------------------
// two_frame_shard_reassembler_core
// Reassembles frames from shards over a window of two frames, releasing
// contiguous runs and reporting done and abandoned frames.
// ----------------------------------------------------------------------------
// Channel | Ports                                   | Transaction
// input   | start, busy, in_*                       | start && !busy
// result  | out_strobe, out_*                       | out_strobe, one cycle
//
// A dropped item passes through fewer sequencer states than a stored one; each
// released shard needs a payload RAM read, then an emit, and each window move
// adds states; the sequencer and single RAM read port set how long busy stays high.
// The last result of an item is on the ports in the first cycle after busy falls.
// Reset is synchronous on rst_n and empties both banks; the payload RAM
// needs no clearing. Results cannot be stalled.
// ----------------------------------------------------------------------------
`include "two_frame_shard_reassembler_core_macros.svh"

module two_frame_shard_reassembler_core
  import tfsr_pkg::*;
#(
  parameter int MAX_SHARDS = DEF_MAX_SHARDS,
  parameter int FRAME_BITS = DEF_FRAME_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_frame_number,
  input  logic [4:0]  in_shard_number,
  input  logic        in_is_final_shard,
  input  logic        in_carries_view_info,
  input  logic [31:0] in_payload_ref,
  output logic        out_strobe,
  output logic [1:0]  out_event_kind,
  output logic [31:0] out_event_frame,
  output logic [31:0] out_released_ref,
  output logic        out_frame_partial,
  output logic        out_end_of_run
);

  localparam int SW     = (MAX_SHARDS > 1) ? $clog2(MAX_SHARDS) : 1;
  localparam int LW     = $clog2(MAX_SHARDS + 1);
  localparam int AW     = SW + 1;
  localparam int MAXRES = MAX_SHARDS + 3;
  localparam int CW     = $clog2(MAXRES + 1);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CHECK  = 9'b000000010,
    S_DISP   = 9'b000000100,
    S_WHOLE1 = 9'b000001000,
    S_ABAND2 = 9'b000010000,
    S_FLUSH  = 9'b000100000,
    S_FL_RD  = 9'b001000000,
    S_FL_EMIT= 9'b010000000,
    S_FIN    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [FRAME_BITS-1:0] fr_r, fr_nxt, cur_r, cur_nxt, diff;
  logic [SW-1:0]         slot_r, slot_nxt;
  logic                  big_r, big_nxt, fin_r, fin_nxt, view_r, view_nxt;
  logic [31:0]           ref_r, ref_nxt;
  logic                  bank_r, bank_nxt;
  logic [1:0][MAX_SHARDS-1:0] pres_r, pres_nxt;
  logic [1:0][LW-1:0]    len_r, len_nxt, ptr_r, ptr_nxt;
  logic [1:0]            finl_r, finl_nxt, fv_r, fv_nxt;
  logic [LW-1:0]         fptr_r, fptr_nxt;
  logic                  whole_r, whole_nxt, ret_r, ret_nxt;
  logic [CW-1:0]         cnt_r;

  logic                  pend_v_r;
  logic [1:0]            pend_kind_r;
  logic [31:0]           pend_frame_r, pend_ref_r;
  logic                  pend_part_r;

  logic                  out_strobe_r, out_part_r, out_eor_r;
  logic [1:0]            out_kind_r;
  logic [31:0]           out_frame_r, out_ref_r;

  logic                  emit, e_part, finish;
  event_kind_t           e_kind;
  logic [FRAME_BITS-1:0] e_frame;
  logic [31:0]           e_ref, e_frame32;
  logic [FRAME_BITS+31:0] in_frame_ext, e_frame_ext;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [31:0]           ram_rdata;

  logic                  wsel, whole_w, gap;
  logic [MAX_SHARDS-1:0] slot_mask, len_mask;
  logic [LW-1:0]         slot_l;
  logic                  accept;

  assign accept       = start && !busy;
  assign busy         = (state_r != S_IDLE);
  assign diff         = fr_r - cur_r;
  assign slot_l       = LW'(slot_r);
  assign in_frame_ext = {{FRAME_BITS{1'b0}}, in_frame_number};
  assign e_frame_ext  = {32'd0, e_frame};
  assign e_frame32    = e_frame_ext[31:0];
  assign ram_raddr    = {bank_r, fptr_r[SW-1:0]};

  tfsr_ram #(
    .WIDTH (32),
    .DEPTH (2 ** AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ref_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // gap below the slot and completeness of the selected bank
  always_comb begin
    wsel = (state_r == S_WHOLE1) ? ~bank_r : bank_r;
    for (int i = 0; i < MAX_SHARDS; i++) begin
      slot_mask[i] = (LW'(i) < slot_l);
      len_mask[i]  = (LW'(i) < len_r[wsel]);
    end
    gap     = |(~pres_r[bank_r] & slot_mask);
    whole_w = (len_r[wsel] != '0) && finl_r[wsel] && (&(pres_r[wsel] | ~len_mask));
  end

  always_comb begin
    state_nxt = state_r;
    fr_nxt    = fr_r;
    slot_nxt  = slot_r;
    big_nxt   = big_r;
    fin_nxt   = fin_r;
    view_nxt  = view_r;
    ref_nxt   = ref_r;
    cur_nxt   = cur_r;
    bank_nxt  = bank_r;
    pres_nxt  = pres_r;
    len_nxt   = len_r;
    ptr_nxt   = ptr_r;
    finl_nxt  = finl_r;
    fv_nxt    = fv_r;
    fptr_nxt  = fptr_r;
    whole_nxt = whole_r;
    ret_nxt   = ret_r;
    ram_we    = 1'b0;
    ram_waddr = {bank_r, slot_r};
    emit      = 1'b0;
    e_kind    = EV_RELEASE;
    e_frame   = cur_r;
    e_ref     = '0;
    e_part    = 1'b0;
    finish    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          fr_nxt    = in_frame_ext[FRAME_BITS-1:0];
          slot_nxt  = SW'(in_shard_number);
          big_nxt   = ({4'd0, in_shard_number} >= 9'(MAX_SHARDS));
          fin_nxt   = in_is_final_shard;
          view_nxt  = in_carries_view_info;
          ref_nxt   = in_payload_ref;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = (big_r || fr_r < cur_r) ? S_FIN : S_DISP;
      end
      S_DISP: begin
        if (diff == '0 || diff == FRAME_BITS'(1)) begin
          // put the shard into the current or the next bank
          if (pres_r[bank_nxt ^ (diff != '0)][slot_r]) begin
            state_nxt = S_FIN;
          end else begin
            pres_nxt[bank_r ^ (diff != '0)][slot_r] = 1'b1;
            ram_we    = 1'b1;
            ram_waddr = {bank_r ^ (diff != '0), slot_r};
            if (slot_l >= len_r[bank_r ^ (diff != '0)]) begin
              len_nxt[bank_r ^ (diff != '0)]  = slot_l + LW'(1);
              finl_nxt[bank_r ^ (diff != '0)] = fin_r;
            end
            if (slot_r == '0) begin
              fv_nxt[bank_r ^ (diff != '0)] = view_r;
            end
            if (diff != '0) begin
              state_nxt = S_WHOLE1;
            end else if (gap) begin
              state_nxt = S_FIN;
            end else begin
              ret_nxt   = 1'b0;
              state_nxt = S_FLUSH;
            end
          end
        end else begin
          emit   = 1'b1;
          e_kind = EV_ABANDON;
          if (diff == FRAME_BITS'(2)) begin
            pres_nxt[bank_r] = '0;
            len_nxt[bank_r]  = '0;
            ptr_nxt[bank_r]  = '0;
            finl_nxt[bank_r] = 1'b0;
            fv_nxt[bank_r]   = 1'b0;
            bank_nxt         = ~bank_r;
            cur_nxt          = cur_r + FRAME_BITS'(1);
            ret_nxt          = 1'b1;
            state_nxt        = S_FLUSH;
          end else begin
            state_nxt = S_ABAND2;
          end
        end
      end
      S_WHOLE1: begin
        if (whole_w) begin
          emit             = 1'b1;
          e_kind           = EV_ABANDON;
          pres_nxt[bank_r] = '0;
          len_nxt[bank_r]  = '0;
          ptr_nxt[bank_r]  = '0;
          finl_nxt[bank_r] = 1'b0;
          fv_nxt[bank_r]   = 1'b0;
          bank_nxt         = ~bank_r;
          cur_nxt          = cur_r + FRAME_BITS'(1);
          ret_nxt          = 1'b0;
          state_nxt        = S_FLUSH;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_ABAND2: begin
        // restart the window at the shard's frame
        emit      = 1'b1;
        e_kind    = EV_ABANDON;
        e_frame   = cur_r + FRAME_BITS'(1);
        pres_nxt  = '0;
        len_nxt   = '0;
        ptr_nxt   = '0;
        finl_nxt  = '0;
        fv_nxt    = '0;
        cur_nxt   = fr_r;
        state_nxt = S_DISP;
      end
      S_FLUSH: begin
        fptr_nxt  = ptr_r[bank_r];
        whole_nxt = whole_w;
        state_nxt = S_FL_RD;
      end
      S_FL_RD: begin
        if (fptr_r < len_r[bank_r] && pres_r[bank_r][fptr_r[SW-1:0]]) begin
          state_nxt = S_FL_EMIT;
        end else begin
          ptr_nxt[bank_r] = fptr_r;
          if (whole_r && fv_r[bank_r]) begin
            emit             = 1'b1;
            e_kind           = EV_DONE;
            pres_nxt[bank_r] = '0;
            len_nxt[bank_r]  = '0;
            ptr_nxt[bank_r]  = '0;
            finl_nxt[bank_r] = 1'b0;
            fv_nxt[bank_r]   = 1'b0;
            bank_nxt         = ~bank_r;
            cur_nxt          = cur_r + FRAME_BITS'(1);
          end
          state_nxt = ret_r ? S_DISP : S_FIN;
        end
      end
      S_FL_EMIT: begin
        emit      = 1'b1;
        e_ref     = ram_rdata;
        e_part    = ~whole_r;
        fptr_nxt  = fptr_r + LW'(1);
        state_nxt = S_FL_RD;
      end
      S_FIN: begin
        finish    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_r   <= '0;
      bank_r  <= 1'b0;
      pres_r  <= '0;
      len_r   <= '0;
      ptr_r   <= '0;
      finl_r  <= '0;
      fv_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      bank_r  <= bank_nxt;
      pres_r  <= pres_nxt;
      len_r   <= len_nxt;
      ptr_r   <= ptr_nxt;
      finl_r  <= finl_nxt;
      fv_r    <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fr_r    <= fr_nxt;
    slot_r  <= slot_nxt;
    big_r   <= big_nxt;
    fin_r   <= fin_nxt;
    view_r  <= view_nxt;
    ref_r   <= ref_nxt;
    fptr_r  <= fptr_nxt;
    whole_r <= whole_nxt;
    ret_r   <= ret_nxt;
  end

  // hold one result back so the last one of a transaction can be marked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      pend_v_r     <= 1'b0;
      out_strobe_r <= 1'b0;
      out_eor_r    <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      out_eor_r    <= 1'b0;
      if (accept) begin
        cnt_r <= '0;
      end
      if (emit && cnt_r < CW'(MAXRES)) begin
        cnt_r        <= cnt_r + CW'(1);
        pend_v_r     <= 1'b1;
        pend_kind_r  <= e_kind;
        pend_frame_r <= e_frame32;
        pend_ref_r   <= e_ref;
        pend_part_r  <= e_part;
        out_strobe_r <= pend_v_r;
      end else if (finish) begin
        pend_v_r     <= 1'b0;
        out_strobe_r <= pend_v_r;
        out_eor_r    <= pend_v_r;
      end
      out_kind_r  <= pend_kind_r;
      out_frame_r <= pend_frame_r;
      out_ref_r   <= pend_ref_r;
      out_part_r  <= pend_part_r;
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_event_kind    = out_kind_r;
  assign out_event_frame   = out_frame_r;
  assign out_released_ref  = out_ref_r;
  assign out_frame_partial = out_part_r;
  assign out_end_of_run    = out_eor_r;

  `TFSR_ASSERT_IMP(ap_eor_strobe, out_end_of_run, out_strobe, "end of run without strobe")
  `TFSR_ASSERT_NXT(ap_accept_busy, start && !busy, busy, "accepted item did not start")
  `TFSR_ASSERT_IMP(ap_ptr_len, 1'b1, ptr_r[0] <= len_r[0] && ptr_r[1] <= len_r[1], "release pointer past frame length")
  `TFSR_ASSERT_IMP(ap_idle_empty, !busy, !pend_v_r, "result held while idle")

endmodule

/* tb/two_frame_shard_reassembler_core_test.sv */
// ----------------------------------------------------------------------------
// Shard reassembler testbench
// Drives random and directed shards into the reassembler, predicts the
// release, done and abandon events, and checks each result transaction.
// ----------------------------------------------------------------------------
module two_frame_shard_reassembler_core_test;
  import tfsr_pkg::*;

  typedef struct packed {
    event_kind_t kind;
    logic [31:0] frame;
    logic [31:0] ref_val;
    logic        partial;
    logic        last;
  } shard_event_t;

  class reassembly_scoreboard;
    logic [31:0]  cur_frame;
    logic         present [2][32];
    logic [31:0]  payload [64];
    int unsigned  length [2];
    logic         fin_seen [2];
    logic         view0 [2];
    int unsigned  rel_ptr [2];
    logic         bank;
    shard_event_t pending [$];
    shard_event_t step_events [$];
    int           errors;
    int           checked;
    int           kind_count [3];

    function void clear_bank(logic b);
      for (int i = 0; i < 32; i++) present[b][i] = 1'b0;
      length[b] = 0;
      fin_seen[b] = 1'b0;
      view0[b] = 1'b0;
      rel_ptr[b] = 0;
    endfunction

    function void init();
      cur_frame = '0;
      bank = 1'b0;
      clear_bank(1'b0);
      clear_bank(1'b1);
      errors = 0;
      checked = 0;
      pending.delete();
    endfunction

    // Drop results beyond the most that one transaction can carry.
    function void push(event_kind_t k, logic [31:0] f, logic [31:0] r, logic p);
      shard_event_t e;
      if (step_events.size() >= 35) return;
      e.kind = k;
      e.frame = f;
      e.ref_val = r;
      e.partial = p;
      e.last = 1'b0;
      step_events.push_back(e);
    endfunction

    function bit store(logic b, int unsigned s, logic fin, logic view, logic [31:0] r);
      if (present[b][s]) return 0;
      present[b][s] = 1'b1;
      payload[b * 32 + s] = r;
      if (s >= length[b]) begin
        length[b] = s + 1;
        fin_seen[b] = fin;
      end
      if (s == 0) view0[b] = view;
      return 1;
    endfunction

    function bit whole(logic b);
      if (length[b] == 0 || !fin_seen[b]) return 0;
      for (int i = 0; i < length[b]; i++) if (!present[b][i]) return 0;
      return 1;
    endfunction

    function void advance();
      clear_bank(bank);
      bank = ~bank;
      cur_frame = cur_frame + 1;
    endfunction

    function void release_run();
      int unsigned stop;
      bit done;
      stop = rel_ptr[bank];
      while (stop < length[bank] && present[bank][stop]) stop++;
      done = (length[bank] > 0) && (stop == length[bank]) && fin_seen[bank];
      for (int i = rel_ptr[bank]; i < stop; i++)
        push(EV_RELEASE, cur_frame, payload[bank * 32 + i], !done);
      rel_ptr[bank] = stop;
      if (done && view0[bank]) begin
        push(EV_DONE, cur_frame, '0, 1'b0);
        advance();
      end
    endfunction

    function void note_shard(logic [31:0] f, logic [4:0] s, logic fin, logic view,
                             logic [31:0] r);
      logic [31:0] diff;
      bit gap;
      step_events.delete();
      if (f >= cur_frame) begin
        forever begin
          diff = f - cur_frame;
          if (diff == 0) begin
            gap = 0;
            if (store(bank, s, fin, view, r)) begin
              for (int i = 0; i < s; i++) if (!present[bank][i]) gap = 1;
              if (!gap) release_run();
            end
            break;
          end else if (diff == 1) begin
            if (store(~bank, s, fin, view, r) && whole(~bank)) begin
              push(EV_ABANDON, cur_frame, '0, 1'b0);
              advance();
              release_run();
            end
            break;
          end else if (diff == 2) begin
            push(EV_ABANDON, cur_frame, '0, 1'b0);
            advance();
            release_run();
          end else begin
            push(EV_ABANDON, cur_frame, '0, 1'b0);
            push(EV_ABANDON, cur_frame + 32'd1, '0, 1'b0);
            clear_bank(1'b0);
            clear_bank(1'b1);
            cur_frame = f;
          end
        end
      end
      if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
      foreach (step_events[i]) pending.push_back(step_events[i]);
    endfunction

    function void check_result(shard_event_t got, output string msg);
      shard_event_t want;
      msg = "";
      checked++;
      if (got.kind <= EV_ABANDON) kind_count[got.kind]++;
      if (pending.size() == 0) begin
        msg = $sformatf("unexpected result kind=%0d frame=%0d", got.kind, got.frame);
        return;
      end
      want = pending.pop_front();
      if (got.kind != want.kind)
        msg = $sformatf("kind got %0d want %0d", got.kind, want.kind);
      else if (got.frame != want.frame)
        msg = $sformatf("frame got %0d want %0d", got.frame, want.frame);
      else if (got.ref_val != want.ref_val)
        msg = $sformatf("ref got %h want %h", got.ref_val, want.ref_val);
      else if (got.partial != want.partial)
        msg = $sformatf("partial got %b want %b", got.partial, want.partial);
      else if (got.last != want.last)
        msg = $sformatf("end_of_run got %b want %b", got.last, want.last);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_frame_number;
  logic [4:0]  in_shard_number;
  logic        in_is_final_shard;
  logic        in_carries_view_info;
  logic [31:0] in_payload_ref;
  logic        out_strobe;
  logic [1:0]  out_event_kind;
  logic [31:0] out_event_frame;
  logic [31:0] out_released_ref;
  logic        out_frame_partial;
  logic        out_end_of_run;

  reassembly_scoreboard board;
  int          fail_count;
  int          shards_sent;
  bit          calm;
  logic [31:0] base_frame;

  two_frame_shard_reassembler_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_frame_number(in_frame_number), .in_shard_number(in_shard_number),
    .in_is_final_shard(in_is_final_shard), .in_carries_view_info(in_carries_view_info),
    .in_payload_ref(in_payload_ref), .out_strobe(out_strobe),
    .out_event_kind(out_event_kind), .out_event_frame(out_event_frame),
    .out_released_ref(out_released_ref), .out_frame_partial(out_frame_partial),
    .out_end_of_run(out_end_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    shard_event_t got;
    string msg;
    if (rst_n && out_strobe) begin
      got.kind = event_kind_t'(out_event_kind);
      got.frame = out_event_frame;
      got.ref_val = out_released_ref;
      got.partial = out_frame_partial;
      got.last = out_end_of_run;
      board.check_result(got, msg);
      if (msg != "") report_mismatch(msg);
    end
  end

  // Present one shard and hold it until the transaction is taken.
  // Start stays high on return; drop it only on an idle gap or a drain.
  task automatic send_shard(input logic [31:0] f, input logic [4:0] s, input logic fin,
                            input logic view, input logic [31:0] r);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_frame_number <= f;
    in_shard_number <= s;
    in_is_final_shard <= fin;
    in_carries_view_info <= view;
    in_payload_ref <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_shard(f, s, fin, view, r);
    shards_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Send a frame of n shards in shuffled order, with random drops and random extras.
  task automatic send_frame(input logic [31:0] f, input int n, input bit view);
    int order [$];
    int j;
    int t;
    for (int i = 0; i < n; i++) order.push_back(i);
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = order.size() - 1; i >= 0; i--) begin
      if ($urandom_range(0, 9) == 0) order.delete(i);
    end
    foreach (order[i]) begin
      send_shard(f, 5'(order[i]), order[i] == n - 1,
                 order[i] == 0 ? view : 1'($urandom_range(0, 1)), $urandom());
      if ($urandom_range(0, 7) == 0)
        send_shard(f, 5'(order[i]), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   $urandom());
    end
  endtask

  initial begin
    board = new();
    board.init();
    fail_count = 0;
    shards_sent = 0;
    calm = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_frame_number = '0;
    in_shard_number = '0;
    in_is_final_shard = 1'b0;
    in_carries_view_info = 1'b0;
    in_payload_ref = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: in-order frame, held shard, duplicate, no view info, old frame.
    send_shard(0, 0, 0, 1, 32'hFFFF_FFFF);
    send_shard(0, 2, 1, 0, 32'h0000_0002);
    send_shard(0, 2, 0, 1, 32'h1234_5678);
    send_shard(0, 1, 0, 0, 32'h0000_0000);
    send_shard(0, 0, 1, 1, 32'hAAAA_AAAA);
    send_shard(1, 0, 1, 0, 32'h5555_5555);
    send_shard(1, 31, 1, 1, 32'h0F0F_0F0F);
    // Next frame completes first.
    send_shard(2, 0, 1, 1, 32'h0000_0020);
    // Two frames ahead, then three or more ahead.
    send_shard(3, 1, 0, 0, 32'h0000_0031);
    send_shard(5, 0, 0, 1, 32'h0000_0050);
    send_shard(1, 0, 1, 1, 32'h0000_0001);
    send_shard(32'hFFFF_FFFE, 0, 1, 1, 32'hCAFE_0000);
    send_shard(32'hFFFF_FFFF, 1, 1, 0, 32'hCAFE_0001);
    send_shard(32'hFFFF_FFFF, 0, 0, 1, 32'hCAFE_0002);
    send_shard(32'hFFFF_FFFF, 0, 1, 1, 32'hCAFE_0003);
    send_shard(32'hFFFF_FFFF, 2, 1, 1, 32'hCAFE_0004);
    send_shard(0, 0, 1, 1, 32'h0000_0000);
    drain();

    base_frame = 32'd100;
    send_shard(base_frame, 0, 0, 0, 32'd7);
    while (shards_sent < 120) begin
      case ($urandom_range(0, 9))
        0: send_shard($urandom(), 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), $urandom());
        1: send_frame(board.cur_frame + 1, $urandom_range(1, 5), 1);
        2: send_frame(board.cur_frame + $urandom_range(2, 4), $urandom_range(1, 3), 1);
        3: send_shard(board.cur_frame - 1, 5'($urandom_range(0, 31)), 1, 1, $urandom());
        default: send_frame(board.cur_frame, $urandom_range(1, 6), $urandom_range(0, 5) != 0);
      endcase
      if (shards_sent > 95) calm = 1;
      if (shards_sent > 50 && shards_sent < 60) drain();
    end
    // Long frame at the top of the shard range.
    send_frame(board.cur_frame, 32, 1);
    drain();

    $display("Sent %0d shards; checked %0d results (%0d releases, %0d done, %0d abandon).",
             shards_sent, board.checked, board.kind_count[0], board.kind_count[1],
             board.kind_count[2]);
    if (fail_count == 0 && board.pending.size() == 0) begin
      $display("two_frame_shard_reassembler_core verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, board.pending.size());
      $display("two_frame_shard_reassembler_core verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout waiting for results");
    $display("two_frame_shard_reassembler_core verification failed");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/tfsr_pkg.sv
rtl/tfsr_ram.sv
rtl/two_frame_shard_reassembler_core.sv
tb/two_frame_shard_reassembler_core_test.sv
